/* src/wfp_pkg.sv */
// WebSocket frame parser package: parse phases, status codes, opcode checks
// and the result record passed from the frame core to the output register.
// No dependencies.
package wfp_pkg;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_SECOND,
    PH_EXTLEN,
    PH_KEY,
    PH_PAYLOAD,
    PH_HALTED
  } phase_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_RSV_BITS = 3'd1;
  localparam logic [2:0] ST_BAD_OPC  = 3'd2;
  localparam logic [2:0] ST_CTRL_FRAG = 3'd3;
  localparam logic [2:0] ST_CTRL_LONG = 3'd4;
  localparam logic [2:0] ST_LEN_MSB  = 3'd5;

  localparam logic [3:0] OPC_CONT  = 4'h0;
  localparam logic [3:0] OPC_TEXT  = 4'h1;
  localparam logic [3:0] OPC_BIN   = 4'h2;
  localparam logic [3:0] OPC_CLOSE = 4'h8;
  localparam logic [3:0] OPC_PING  = 4'h9;
  localparam logic [3:0] OPC_PONG  = 4'hA;

  localparam logic [6:0] LEN_CTRL_MAX = 7'd125;
  localparam logic [6:0] LEN_EXT16    = 7'd126;
  localparam logic [6:0] LEN_EXT64    = 7'd127;

  localparam logic [2:0] EXT16_BYTES_M1 = 3'd1;
  localparam logic [2:0] EXT64_BYTES_M1 = 3'd7;
  localparam logic [2:0] KEY_BYTES_M1   = 3'd3;

  typedef struct packed {
    logic       has;
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic [3:0] frame_opcode;
    logic       final_fragment;
    logic       last_of_frame;
    logic [2:0] status;
  } result_t;

  function automatic logic opcode_known(input logic [3:0] opc);
    return (opc == OPC_CONT) || (opc == OPC_TEXT) || (opc == OPC_BIN) ||
           (opc == OPC_CLOSE) || (opc == OPC_PING) || (opc == OPC_PONG);
  endfunction

endpackage

/* src/wfp_core.sv */
// Frame core: header parse state, length counter, mask key and unmasking.
// Processes one byte per step and reports at most one result.
// Depends on wfp_pkg.
module wfp_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       data_byte,
  output wfp_pkg::result_t res
);

  wfp_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        fin_r, fin_nxt;
  logic        masked_r, masked_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  key_idx_r, key_idx_nxt;

  logic       hdr_done;
  logic       err;
  logic [2:0] err_st;
  logic [3:0] err_opc;
  logic       err_fin;
  logic [6:0] code;
  logic [7:0] key_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= wfp_pkg::PH_FIRST;
      hdr_cnt_r <= '0;
      opcode_r  <= '0;
      fin_r     <= 1'b0;
      masked_r  <= 1'b0;
      rem_r     <= '0;
      key_r     <= '0;
      key_idx_r <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      opcode_r  <= opcode_nxt;
      fin_r     <= fin_nxt;
      masked_r  <= masked_nxt;
      rem_r     <= rem_nxt;
      key_r     <= key_nxt;
      key_idx_r <= key_idx_nxt;
    end
  end

  always_comb begin
    unique case (key_idx_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  assign code = data_byte[6:0];

  always_comb begin
    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    opcode_nxt  = opcode_r;
    fin_nxt     = fin_r;
    masked_nxt  = masked_r;
    rem_nxt     = rem_r;
    key_nxt     = key_r;
    key_idx_nxt = key_idx_r;
    hdr_done    = 1'b0;
    err         = 1'b0;
    err_st      = wfp_pkg::ST_OK;
    err_opc     = opcode_r;
    err_fin     = fin_r;
    res         = '0;

    unique case (phase_r)
      wfp_pkg::PH_FIRST: begin
        err_opc = data_byte[3:0];
        err_fin = data_byte[7];
        if (data_byte[6:4] != 3'd0) begin
          err    = 1'b1;
          err_st = wfp_pkg::ST_RSV_BITS;
        end else if (!wfp_pkg::opcode_known(data_byte[3:0])) begin
          err    = 1'b1;
          err_st = wfp_pkg::ST_BAD_OPC;
        end else begin
          opcode_nxt = data_byte[3:0];
          fin_nxt    = data_byte[7];
          phase_nxt  = wfp_pkg::PH_SECOND;
        end
      end
      wfp_pkg::PH_SECOND: begin
        masked_nxt = data_byte[7];
        if (opcode_r[3] && !fin_r) begin
          err    = 1'b1;
          err_st = wfp_pkg::ST_CTRL_FRAG;
        end else if (opcode_r[3] && (code > wfp_pkg::LEN_CTRL_MAX)) begin
          err    = 1'b1;
          err_st = wfp_pkg::ST_CTRL_LONG;
        end else begin
          key_nxt = '0;
          if ((code == wfp_pkg::LEN_EXT16) || (code == wfp_pkg::LEN_EXT64)) begin
            rem_nxt     = '0;
            hdr_cnt_nxt = (code == wfp_pkg::LEN_EXT16) ? wfp_pkg::EXT16_BYTES_M1
                                                       : wfp_pkg::EXT64_BYTES_M1;
            phase_nxt   = wfp_pkg::PH_EXTLEN;
          end else begin
            rem_nxt = {57'd0, code};
            if (data_byte[7]) begin
              hdr_cnt_nxt = wfp_pkg::KEY_BYTES_M1;
              phase_nxt   = wfp_pkg::PH_KEY;
            end else begin
              hdr_done = 1'b1;
            end
          end
        end
      end
      wfp_pkg::PH_EXTLEN: begin
        rem_nxt = {rem_r[55:0], data_byte};
        if (hdr_cnt_r != 3'd0) begin
          hdr_cnt_nxt = hdr_cnt_r - 3'd1;
        end else if (rem_nxt[63]) begin
          err    = 1'b1;
          err_st = wfp_pkg::ST_LEN_MSB;
        end else if (masked_r) begin
          hdr_cnt_nxt = wfp_pkg::KEY_BYTES_M1;
          phase_nxt   = wfp_pkg::PH_KEY;
        end else begin
          hdr_done = 1'b1;
        end
      end
      wfp_pkg::PH_KEY: begin
        key_nxt = {key_r[23:0], data_byte};
        if (hdr_cnt_r != 3'd0) begin
          hdr_cnt_nxt = hdr_cnt_r - 3'd1;
        end else begin
          hdr_done = 1'b1;
        end
      end
      wfp_pkg::PH_PAYLOAD: begin
        key_idx_nxt = key_idx_r + 2'd1;
        rem_nxt     = rem_r - 64'd1;
        res.has            = 1'b1;
        res.payload_byte   = masked_r ? (data_byte ^ key_byte) : data_byte;
        res.payload_valid  = 1'b1;
        res.frame_opcode   = opcode_r;
        res.final_fragment = fin_r;
        res.status         = wfp_pkg::ST_OK;
        if (rem_nxt == 64'd0) begin
          res.last_of_frame = 1'b1;
          phase_nxt         = wfp_pkg::PH_FIRST;
          key_idx_nxt       = '0;
        end
      end
      wfp_pkg::PH_HALTED: begin
      end
      default: begin
        phase_nxt = wfp_pkg::PH_HALTED;
      end
    endcase

    if (hdr_done) begin
      key_idx_nxt = '0;
      if (rem_nxt == 64'd0) begin
        phase_nxt          = wfp_pkg::PH_FIRST;
        res.has            = 1'b1;
        res.frame_opcode   = opcode_r;
        res.final_fragment = fin_r;
        res.last_of_frame  = 1'b1;
        res.status         = wfp_pkg::ST_OK;
      end else begin
        phase_nxt = wfp_pkg::PH_PAYLOAD;
      end
    end

    if (err) begin
      phase_nxt          = wfp_pkg::PH_HALTED;
      res.has            = 1'b1;
      res.payload_byte   = '0;
      res.payload_valid  = 1'b0;
      res.frame_opcode   = err_opc;
      res.final_fragment = err_fin;
      res.last_of_frame  = 1'b0;
      res.status         = err_st;
    end
  end

endmodule

/* src/websocket_frame_parser.sv */
// WebSocket frame parser top level: input register, frame core, result register.
// Depends on wfp_pkg and wfp_core.

// Receive-side RFC 6455 frame parser. Stream bytes enter on in_data_byte, one
// per transaction, and may be offered every cycle. A byte is captured in the
// input register, the frame core decodes it there combinationally, and its
// result is written to the result register when the core steps; a stalled,
// full result register holds the byte in the input register. Throughput is one
// byte per cycle while the result side does not stall. Header bytes give no
// result except a zero-length frame (one result, out_payload_valid low,
// out_last_of_frame high) or an error. Payload bytes come out unmasked, one
// result each, with opcode and fin; the last carries out_last_of_frame. An
// error gives one status result and the parser then drops all bytes until
// reset.
module websocket_frame_parser (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_payload_byte,
  output logic       out_payload_valid,
  output logic [3:0] out_frame_opcode,
  output logic       out_final_fragment,
  output logic       out_last_of_frame,
  output logic [2:0] out_status
);

  logic             in_valid_r;
  logic [7:0]       in_byte_r;
  logic             out_valid_r;
  wfp_pkg::result_t out_r;
  wfp_pkg::result_t res;
  logic             advance;
  logic             in_take;

  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_data_byte;
    end
  end

  wfp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .data_byte (in_byte_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res.has) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.has) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_payload_byte   = out_r.payload_byte;
  assign out_payload_valid  = out_r.payload_valid;
  assign out_frame_opcode   = out_r.frame_opcode;
  assign out_final_fragment = out_r.final_fragment;
  assign out_last_of_frame  = out_r.last_of_frame;
  assign out_status         = out_r.status;

`ifndef ASSERT_OFF
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_payload_valid) |-> (out_status == wfp_pkg::ST_OK))
    else $error("payload result carries an error status");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != wfp_pkg::ST_OK)) |->
      (!out_payload_valid && !out_last_of_frame && (out_payload_byte == 8'd0)))
    else $error("malformed error result");

  a_halt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && (out_status != wfp_pkg::ST_OK)) |=> !out_valid)
    else $error("result after an error");
`endif

endmodule

/* tb/websocket_frame_parser_tb.sv */
// Self-checking testbench for websocket_frame_parser: a directed frame table,
// then random well-formed frames and one error frame, checked against a
// byte-level parser model. Depends on wfp_pkg and the websocket_frame_parser RTL.
module websocket_frame_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]       b;
    logic             typed;
    wfp_pkg::result_t want;
  } stim_row_t;

  localparam wfp_pkg::result_t NO_RES = '0;
  localparam int DIR_N = 27;
  localparam int RAND_ITEMS = 1500;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_data_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_payload_byte;
  logic       out_payload_valid;
  logic [3:0] out_frame_opcode;
  logic       out_final_fragment;
  logic       out_last_of_frame;
  logic [2:0] out_status;

  websocket_frame_parser u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_payload_byte   (out_payload_byte),
    .out_payload_valid  (out_payload_valid),
    .out_frame_opcode   (out_frame_opcode),
    .out_final_fragment (out_final_fragment),
    .out_last_of_frame  (out_last_of_frame),
    .out_status         (out_status)
  );

  // parser model state
  wfp_pkg::phase_t st_phase;
  logic [2:0]      st_count;
  logic [3:0]      st_opc;
  logic            st_fin;
  logic            st_masked;
  logic [63:0]     st_remain;
  logic [31:0]     st_key;
  logic [1:0]      st_kidx;

  stim_row_t        stim_q[$];
  wfp_pkg::result_t decoded_q[$];
  int               mismatches = 0;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;

  function automatic wfp_pkg::result_t make_result(logic [7:0] d, logic v, logic [3:0] o,
                                                   logic f, logic l, logic [2:0] s);
    wfp_pkg::result_t r;
    r.has = 1'b1;
    r.payload_byte = d;
    r.payload_valid = v;
    r.frame_opcode = o;
    r.final_fragment = f;
    r.last_of_frame = l;
    r.status = s;
    return r;
  endfunction

  function automatic wfp_pkg::result_t halt_parser(logic [3:0] o, logic f, logic [2:0] s);
    st_phase = wfp_pkg::PH_HALTED;
    return make_result(8'h00, 1'b0, o, f, 1'b0, s);
  endfunction

  function automatic wfp_pkg::result_t finish_header();
    st_kidx = 2'd0;
    if (st_remain == 64'd0) begin
      st_phase = wfp_pkg::PH_FIRST;
      return make_result(8'h00, 1'b0, st_opc, st_fin, 1'b1, wfp_pkg::ST_OK);
    end
    st_phase = wfp_pkg::PH_PAYLOAD;
    return NO_RES;
  endfunction

  function automatic logic known_opcode(logic [3:0] o);
    unique case (o)
      wfp_pkg::OPC_CONT, wfp_pkg::OPC_TEXT, wfp_pkg::OPC_BIN,
      wfp_pkg::OPC_CLOSE, wfp_pkg::OPC_PING, wfp_pkg::OPC_PONG: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic wfp_pkg::result_t decode_stream_byte(logic [7:0] b);
    wfp_pkg::result_t r;
    logic [6:0]       code;
    logic [7:0]       data;
    r = NO_RES;
    unique case (st_phase)
      wfp_pkg::PH_FIRST: begin
        if (b[6:4] != 3'd0) begin
          r = halt_parser(b[3:0], b[7], wfp_pkg::ST_RSV_BITS);
        end else if (!known_opcode(b[3:0])) begin
          r = halt_parser(b[3:0], b[7], wfp_pkg::ST_BAD_OPC);
        end else begin
          st_opc = b[3:0];
          st_fin = b[7];
          st_phase = wfp_pkg::PH_SECOND;
        end
      end
      wfp_pkg::PH_SECOND: begin
        code = b[6:0];
        st_masked = b[7];
        if (st_opc[3] && !st_fin) begin
          r = halt_parser(st_opc, st_fin, wfp_pkg::ST_CTRL_FRAG);
        end else if (st_opc[3] && code > wfp_pkg::LEN_CTRL_MAX) begin
          r = halt_parser(st_opc, st_fin, wfp_pkg::ST_CTRL_LONG);
        end else begin
          st_key = '0;
          if (code == wfp_pkg::LEN_EXT16 || code == wfp_pkg::LEN_EXT64) begin
            st_remain = '0;
            st_count = (code == wfp_pkg::LEN_EXT16) ? wfp_pkg::EXT16_BYTES_M1
                                                    : wfp_pkg::EXT64_BYTES_M1;
            st_phase = wfp_pkg::PH_EXTLEN;
          end else begin
            st_remain = 64'(code);
            if (st_masked) begin
              st_count = wfp_pkg::KEY_BYTES_M1;
              st_phase = wfp_pkg::PH_KEY;
            end else r = finish_header();
          end
        end
      end
      wfp_pkg::PH_EXTLEN: begin
        st_remain = {st_remain[55:0], b};
        if (st_count != 3'd0) st_count = st_count - 3'd1;
        else if (st_remain[63]) r = halt_parser(st_opc, st_fin, wfp_pkg::ST_LEN_MSB);
        else if (st_masked) begin
          st_count = wfp_pkg::KEY_BYTES_M1;
          st_phase = wfp_pkg::PH_KEY;
        end else r = finish_header();
      end
      wfp_pkg::PH_KEY: begin
        st_key = {st_key[23:0], b};
        if (st_count != 3'd0) st_count = st_count - 3'd1;
        else r = finish_header();
      end
      wfp_pkg::PH_PAYLOAD: begin
        data = st_masked ? b ^ st_key[8 * (3 - int'(st_kidx)) +: 8] : b;
        st_kidx = st_kidx + 2'd1;
        st_remain = st_remain - 64'd1;
        if (st_remain == 64'd0) begin
          st_phase = wfp_pkg::PH_FIRST;
          st_kidx = 2'd0;
        end
        r = make_result(data, 1'b1, st_opc, st_fin, st_remain == 64'd0, wfp_pkg::ST_OK);
      end
      default: r = NO_RES;
    endcase
    return r;
  endfunction

  task automatic add_row(logic [7:0] b, logic typed, wfp_pkg::result_t want);
    stim_row_t row;
    row.b = b;
    row.typed = typed;
    row.want = want;
    stim_q.insert(stim_q.size(), row);
  endtask

  // lo..hi index into cont, text, bin, close, ping, pong
  function automatic logic [3:0] pick_opcode(int lo, int hi);
    logic [3:0] opcs [6];
    opcs = '{wfp_pkg::OPC_CONT, wfp_pkg::OPC_TEXT, wfp_pkg::OPC_BIN,
             wfp_pkg::OPC_CLOSE, wfp_pkg::OPC_PING, wfp_pkg::OPC_PONG};
    return opcs[$urandom_range(lo, hi)];
  endfunction

  task automatic add_random_frame();
    logic [3:0]  opc;
    logic        fin;
    logic        msk;
    logic [6:0]  code;
    logic [63:0] len;
    int          form;
    int          pick;
    opc = pick_opcode(0, 5);
    msk = 1'($urandom_range(0, 1));
    form = 0;
    if (opc[3]) begin
      fin = 1'b1;
      len = ($urandom_range(0, 9) == 0) ? 64'd125 : 64'($urandom_range(0, 12));
    end else begin
      fin = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      if (pick < 6) len = ($urandom_range(0, 19) == 0) ? 64'd125 : 64'($urandom_range(0, 20));
      else begin
        form = (pick < 8) ? 1 : 2;
        len = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 3))
                                          : 64'($urandom_range(0, 300));
      end
    end
    code = (form == 0) ? len[6:0] : (form == 1) ? wfp_pkg::LEN_EXT16 : wfp_pkg::LEN_EXT64;
    add_row({fin, 3'b000, opc}, 1'b0, NO_RES);
    add_row({msk, code}, 1'b0, NO_RES);
    if (form == 1) begin
      add_row(len[15:8], 1'b0, NO_RES);
      add_row(len[7:0], 1'b0, NO_RES);
    end else if (form == 2) begin
      for (int i = 7; i >= 0; i--) add_row(8'(len >> (8 * i)), 1'b0, NO_RES);
    end
    if (msk) repeat (4) add_row(8'($urandom), 1'b0, NO_RES);
    for (int i = 0; i < int'(len); i++) add_row(8'($urandom), 1'b0, NO_RES);
  endtask

  // one protocol error closes the run; the parser stays halted afterwards
  task automatic add_error_tail();
    logic [7:0] b;
    logic [3:0] opc;
    logic       fin;
    int         k;
    b = 8'($urandom);
    unique case ($urandom_range(1, 5))
      1: begin
        b[6:4] = 3'($urandom_range(1, 7));
        add_row(b, 1'b1, make_result(8'h00, 1'b0, b[3:0], b[7], 1'b0, wfp_pkg::ST_RSV_BITS));
      end
      2: begin
        k = $urandom_range(0, 9);
        b[6:4] = 3'b000;
        b[3:0] = (k < 5) ? 4'(3 + k) : 4'(6 + k);
        add_row(b, 1'b1, make_result(8'h00, 1'b0, b[3:0], b[7], 1'b0, wfp_pkg::ST_BAD_OPC));
      end
      3: begin
        opc = pick_opcode(3, 5);
        add_row({4'b0000, opc}, 1'b0, NO_RES);
        add_row(b, 1'b1, make_result(8'h00, 1'b0, opc, 1'b0, 1'b0, wfp_pkg::ST_CTRL_FRAG));
      end
      4: begin
        opc = pick_opcode(3, 5);
        add_row({4'b1000, opc}, 1'b0, NO_RES);
        add_row({b[7], 7'($urandom_range(126, 127))}, 1'b1,
                make_result(8'h00, 1'b0, opc, 1'b1, 1'b0, wfp_pkg::ST_CTRL_LONG));
      end
      default: begin
        opc = pick_opcode(0, 2);
        fin = 1'($urandom_range(0, 1));
        add_row({fin, 3'b000, opc}, 1'b0, NO_RES);
        add_row({b[7], wfp_pkg::LEN_EXT64}, 1'b0, NO_RES);
        add_row({1'b1, 7'($urandom)}, 1'b0, NO_RES);
        repeat (6) add_row(8'($urandom), 1'b0, NO_RES);
        add_row(8'($urandom), 1'b1,
                make_result(8'h00, 1'b0, opc, fin, 1'b0, wfp_pkg::ST_LEN_MSB));
      end
    endcase
    repeat (12) add_row(8'($urandom), 1'b0, NO_RES);
  endtask

  task automatic cmp_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    wfp_pkg::result_t want;
    if (decoded_q.size() == 0) begin
      $error("unexpected transaction: payload_byte %0h status %0d", out_payload_byte, out_status);
      mismatches++;
    end else begin
      want = decoded_q.pop_front();
      cmp_field("payload_byte", want.payload_byte, out_payload_byte);
      cmp_field("payload_valid", 8'(want.payload_valid), 8'(out_payload_valid));
      cmp_field("frame_opcode", 8'(want.frame_opcode), 8'(out_frame_opcode));
      cmp_field("final_fragment", 8'(want.final_fragment), 8'(out_final_fragment));
      cmp_field("last_of_frame", 8'(want.last_of_frame), 8'(out_last_of_frame));
      cmp_field("status", 8'(want.status), 8'(out_status));
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) check_result();
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  initial begin
    stim_row_t        dir_tab [DIR_N];
    wfp_pkg::result_t pred;
    int               pos;
    int               n;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data_byte <= 8'h00;
    st_phase = wfp_pkg::PH_FIRST;
    st_count = '0;
    st_opc = '0;
    st_fin = 1'b0;
    st_masked = 1'b0;
    st_remain = '0;
    st_key = '0;
    st_kidx = '0;

    dir_tab = '{
      '{8'h81, 1'b0, NO_RES},
      '{8'h00, 1'b1, make_result(8'h00, 1'b0, wfp_pkg::OPC_TEXT, 1'b1, 1'b1, wfp_pkg::ST_OK)},
      '{8'h02, 1'b0, NO_RES},
      '{8'h02, 1'b0, NO_RES},
      '{8'h00, 1'b1, make_result(8'h00, 1'b1, wfp_pkg::OPC_BIN, 1'b0, 1'b0, wfp_pkg::ST_OK)},
      '{8'hFF, 1'b1, make_result(8'hFF, 1'b1, wfp_pkg::OPC_BIN, 1'b0, 1'b1, wfp_pkg::ST_OK)},
      '{8'h80, 1'b0, NO_RES},
      '{8'h81, 1'b0, NO_RES},
      '{8'hFF, 1'b0, NO_RES},
      '{8'h00, 1'b0, NO_RES},
      '{8'hA5, 1'b0, NO_RES},
      '{8'h5A, 1'b0, NO_RES},
      '{8'h0F, 1'b0, NO_RES},
      '{8'h89, 1'b0, NO_RES},
      '{8'h00, 1'b1, make_result(8'h00, 1'b0, wfp_pkg::OPC_PING, 1'b1, 1'b1, wfp_pkg::ST_OK)},
      '{8'h8A, 1'b0, NO_RES},
      '{8'h80, 1'b0, NO_RES},
      '{8'h12, 1'b0, NO_RES},
      '{8'h34, 1'b0, NO_RES},
      '{8'h56, 1'b0, NO_RES},
      '{8'h78, 1'b1, make_result(8'h00, 1'b0, wfp_pkg::OPC_PONG, 1'b1, 1'b1, wfp_pkg::ST_OK)},
      '{8'h88, 1'b0, NO_RES},
      '{8'h00, 1'b1, make_result(8'h00, 1'b0, wfp_pkg::OPC_CLOSE, 1'b1, 1'b1, wfp_pkg::ST_OK)},
      '{8'h01, 1'b0, NO_RES},
      '{8'h7E, 1'b0, NO_RES},
      '{8'h00, 1'b0, NO_RES},
      '{8'h00, 1'b1, make_result(8'h00, 1'b0, wfp_pkg::OPC_TEXT, 1'b0, 1'b1, wfp_pkg::ST_OK)}
    };
    foreach (dir_tab[i]) stim_q.insert(stim_q.size(), dir_tab[i]);
    while (stim_q.size() < DIR_N + RAND_ITEMS) add_random_frame();
    add_error_tail();
    n = stim_q.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    pos = 0;
    while (pos < n) begin
      @(posedge clk);
      if (in_valid && !in_stall) begin
        pred = decode_stream_byte(stim_q[pos].b);
        if (stim_q[pos].typed) decoded_q.insert(decoded_q.size(), stim_q[pos].want);
        else if (pred.has) decoded_q.insert(decoded_q.size(), pred);
        pos++;
      end
      if (pos < n / 3) begin
        send_idle_pct = 23;
        recv_idle_pct = 48;
      end else if (pos < 2 * n / 3) begin
        send_idle_pct = 48;
        recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (!(in_valid && in_stall)) begin
        if (pos < n && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data_byte <= stim_q[pos].b;
        end else begin
          in_valid <= 1'b0;
          in_data_byte <= 8'($urandom);
        end
      end
    end

    while (decoded_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* websocket_frame_parser.f */
src/wfp_pkg.sv
src/wfp_core.sv
src/websocket_frame_parser.sv
tb/websocket_frame_parser_tb.sv
